[sv/q_encoded_word_decoder_macros.svh]
// ----------------------------------------------------------------------------
// Q-encoded word decoder assertion macros
// Clocked assertion wrappers used by the decoder's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef Q_ENCODED_WORD_DECODER_MACROS_SVH
`define Q_ENCODED_WORD_DECODER_MACROS_SVH

// check on every rising edge outside reset
`define QEWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every rising edge, reset included
`define QEWD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/qewd_pkg.sv]
// ----------------------------------------------------------------------------
// Q-encoded word decoder package
// Character codes, scanner phases, step result type and helper functions.
// ----------------------------------------------------------------------------
package qewd_pkg;

  localparam int QEWD_MAX_CHARSET = 32;

  localparam logic [7:0] CH_EQ = 8'h3D;  // '='
  localparam logic [7:0] CH_QM = 8'h3F;  // '?'
  localparam logic [7:0] CH_Q  = 8'h51;  // 'Q'
  localparam logic [7:0] CH_US = 8'h5F;  // '_'
  localparam logic [7:0] CH_SP = 8'h20;  // ' '

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_EQ   = 3'd1,
    PH_HEX  = 3'd2,
    PH_CSET = 3'd3,
    PH_ENC  = 3'd4,
    PH_Q    = 3'd5,
    PH_END  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ACT_CONSUME = 2'd0,
    ACT_HOLD    = 2'd1,
    ACT_FAIL    = 2'd2
  } act_t;

  typedef struct packed {
    act_t        act;
    phase_t      phase;
    logic        emit;
    logic [7:0]  emit_byte;
    logic        in_word;
    logic        skip;
    logic        hi_ld;
    logic [3:0]  hi;
  } scan_res_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
        return {1'b1, d[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - 8'd55;
        return {1'b1, d[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'd87;
        return {1'b1, d[3:0]};
      end
      return 5'd0;
    end
  endfunction

  // first held byte of an undecided sequence
  function automatic logic [7:0] fail_byte(input phase_t ph);
    return (ph == PH_END) ? CH_QM : CH_EQ;
  endfunction

endpackage

[sv/qewd_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module qewd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/qewd_scan.sv]
// ----------------------------------------------------------------------------
// Q-encoded word decoder scan step
// Decides the action for one scanned byte in the current scanner phase.
// ----------------------------------------------------------------------------
module qewd_scan import qewd_pkg::*; #(
  parameter int MAX_CHARSET = QEWD_MAX_CHARSET,
  parameter int CNT_W       = 6
) (
  input  phase_t           phase_i,
  input  logic [7:0]       c_i,
  input  logic             in_word_i,
  input  logic             skip_i,
  input  logic [3:0]       hi_i,
  input  logic [CNT_W-1:0] pend_cnt_i,
  output scan_res_t        res_o
);

  localparam logic [CNT_W-1:0] HOLD_LIM = CNT_W'(MAX_CHARSET + 2);

  logic [4:0] hex;
  logic       fail;

  assign hex = hex_decode(c_i);

  always_comb begin
    res_o           = '0;
    res_o.act       = ACT_CONSUME;
    res_o.phase     = phase_i;
    res_o.emit_byte = c_i;
    res_o.in_word   = in_word_i;
    res_o.skip      = skip_i;
    res_o.hi        = hex[3:0];
    fail            = 1'b0;
    unique case (phase_i)
      PH_IDLE: begin
        res_o.skip = 1'b0;
        priority if (skip_i && c_i == CH_SP) begin
          res_o.act = ACT_CONSUME;
        end else if (c_i == CH_EQ) begin
          res_o.act   = ACT_HOLD;
          res_o.phase = PH_EQ;
        end else if (c_i == CH_QM && in_word_i) begin
          res_o.act   = ACT_HOLD;
          res_o.phase = PH_END;
        end else if (c_i == CH_US && in_word_i) begin
          res_o.emit      = 1'b1;
          res_o.emit_byte = CH_SP;
        end else begin
          res_o.emit = 1'b1;
        end
      end
      PH_EQ: begin
        priority if (c_i == CH_QM) begin
          res_o.act   = ACT_HOLD;
          res_o.phase = PH_CSET;
        end else if (hex[4]) begin
          res_o.act   = ACT_HOLD;
          res_o.phase = PH_HEX;
          res_o.hi_ld = 1'b1;
        end else begin
          fail = 1'b1;
        end
      end
      PH_HEX: begin
        if (hex[4]) begin
          res_o.emit      = 1'b1;
          res_o.emit_byte = {hi_i, hex[3:0]};
          res_o.phase     = PH_IDLE;
        end else begin
          fail = 1'b1;
        end
      end
      PH_CSET: begin
        priority if (c_i == CH_QM) begin
          res_o.act   = ACT_HOLD;
          res_o.phase = PH_ENC;
        end else if (pend_cnt_i < HOLD_LIM) begin
          res_o.act = ACT_HOLD;
        end else begin
          fail = 1'b1;
        end
      end
      PH_ENC: begin
        if (c_i == CH_Q) begin
          res_o.act   = ACT_HOLD;
          res_o.phase = PH_Q;
        end else begin
          fail = 1'b1;
        end
      end
      PH_Q: begin
        if (c_i == CH_QM) begin
          res_o.in_word = 1'b1;
          res_o.phase   = PH_IDLE;
        end else begin
          fail = 1'b1;
        end
      end
      PH_END: begin
        if (c_i == CH_EQ) begin
          res_o.in_word = 1'b0;
          res_o.skip    = 1'b1;
          res_o.phase   = PH_IDLE;
        end else begin
          fail = 1'b1;
        end
      end
      default: begin
        fail = 1'b1;
      end
    endcase
    if (fail) begin
      res_o.act       = ACT_FAIL;
      res_o.phase     = PH_IDLE;
      res_o.emit      = 1'b1;
      res_o.emit_byte = fail_byte(phase_i);
      res_o.hi_ld     = 1'b0;
    end
  end

endmodule

[sv/q_encoded_word_decoder.sv]
// ----------------------------------------------------------------------------
// Q-encoded word decoder
// Streaming decoder for header text with Q-encoded words and hex escapes.
// ----------------------------------------------------------------------------
// Takes one text byte per transfer and returns its decoded bytes, one per
// result transfer. Every accepted byte is written to a circular byte buffer;
// a single scan unit then walks the buffer, reading each scanned byte from
// RAM and then executing on it. An item passes through an accept step, a
// read and an execute step per byte scanned, then closes with an empty read
// and the flush. A failed opener or escape releases its first byte and
// rescans the rest; a failed opener holds up to MAX_CHARSET + 4 bytes, and a
// sequence that fails again inside that rescan is rescanned in turn. At end
// of text each held sequence is released by force and then rescanned. A
// result that is due while the result channel stalls holds the scan. The
// block takes no new byte until the current one is fully scanned. Each
// result is held back until the next one is found or the item closes, so
// that the final result of a text can carry out_last; a text byte with
// is_last set that yields nothing returns one result with out_valid low.
`include "q_encoded_word_decoder_macros.svh"

module q_encoded_word_decoder import qewd_pkg::*; #(
  parameter int MAX_CHARSET = QEWD_MAX_CHARSET
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_is_last,
  output logic       out_rvalid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);

  localparam int PEND_DEPTH = MAX_CHARSET + 4;
  localparam int BUF_DEPTH  = 1 << $clog2(MAX_CHARSET + 6);
  localparam int PTR_W      = $clog2(BUF_DEPTH);
  localparam logic [PTR_W-1:0] PEND_LIM = PTR_W'(PEND_DEPTH);
  localparam logic [PTR_W-1:0] FILL_LIM = PTR_W'(PEND_DEPTH + 1);

  typedef enum logic [3:0] {
    SQ_IDLE  = 4'b0001,
    SQ_READ  = 4'b0010,
    SQ_EXEC  = 4'b0100,
    SQ_FLUSH = 4'b1000
  } seq_t;

  seq_t             seq_r, seq_nxt;
  phase_t           phase_r, phase_nxt;
  logic             in_word_r, in_word_nxt;
  logic             skip_r, skip_nxt;
  logic             last_r, last_nxt;
  logic [PTR_W-1:0] h_r, h_nxt;
  logic [PTR_W-1:0] s_r, s_nxt;
  logic [PTR_W-1:0] t_r, t_nxt;
  logic [3:0]       hi_r, hi_nxt;
  logic             hb_vld_r, hb_vld_nxt;
  logic [7:0]       hb_byte_r, hb_byte_nxt;
  logic             out_rvalid_r, out_rvalid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_flag_r, out_flag_nxt;
  logic             out_last_r, out_last_nxt;

  logic             wr_en;
  logic [7:0]       rd_data;
  logic [PTR_W-1:0] pend_cnt;
  logic             out_free;
  logic             emit;
  logic [7:0]       emit_byte;
  scan_res_t        res;

  assign in_stall   = (seq_r != SQ_IDLE);
  assign out_rvalid = out_rvalid_r;
  assign out_byte   = out_byte_r;
  assign out_valid  = out_flag_r;
  assign out_last   = out_last_r;
  assign out_free   = !out_rvalid_r || !out_stall;
  assign pend_cnt   = s_r - h_r;

  qewd_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (t_r),
    .wr_data (in_byte),
    .rd_addr (s_r),
    .rd_data (rd_data)
  );

  qewd_scan #(
    .MAX_CHARSET (MAX_CHARSET),
    .CNT_W       (PTR_W)
  ) u_scan (
    .phase_i    (phase_r),
    .c_i        (rd_data),
    .in_word_i  (in_word_r),
    .skip_i     (skip_r),
    .hi_i       (hi_r),
    .pend_cnt_i (pend_cnt),
    .res_o      (res)
  );

  always_comb begin
    seq_nxt        = seq_r;
    phase_nxt      = phase_r;
    in_word_nxt    = in_word_r;
    skip_nxt       = skip_r;
    last_nxt       = last_r;
    h_nxt          = h_r;
    s_nxt          = s_r;
    t_nxt          = t_r;
    hi_nxt         = hi_r;
    hb_vld_nxt     = hb_vld_r;
    hb_byte_nxt    = hb_byte_r;
    out_rvalid_nxt = out_rvalid_r && out_stall;
    out_byte_nxt   = out_byte_r;
    out_flag_nxt   = out_flag_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    emit           = 1'b0;
    emit_byte      = 8'd0;

    unique case (seq_r)
      SQ_IDLE: begin
        if (in_valid) begin
          wr_en    = 1'b1;
          t_nxt    = t_r + PTR_W'(1);
          last_nxt = in_is_last;
          seq_nxt  = SQ_READ;
        end
      end
      SQ_READ: begin
        priority if (s_r != t_r) begin
          seq_nxt = SQ_EXEC;
        end else if (last_r && phase_r != PH_IDLE) begin
          // end of text: release the held sequence and rescan it
          if (out_free) begin
            emit      = 1'b1;
            emit_byte = fail_byte(phase_r);
            h_nxt     = h_r + PTR_W'(1);
            s_nxt     = h_r + PTR_W'(1);
            phase_nxt = PH_IDLE;
          end
        end else begin
          seq_nxt = SQ_FLUSH;
        end
      end
      SQ_EXEC: begin
        if (out_free) begin
          emit        = res.emit;
          emit_byte   = res.emit_byte;
          phase_nxt   = res.phase;
          in_word_nxt = res.in_word;
          skip_nxt    = res.skip;
          if (res.hi_ld) begin
            hi_nxt = res.hi;
          end
          unique case (res.act)
            ACT_CONSUME: begin
              s_nxt = s_r + PTR_W'(1);
              h_nxt = s_r + PTR_W'(1);
            end
            ACT_HOLD: begin
              s_nxt = s_r + PTR_W'(1);
            end
            ACT_FAIL: begin
              h_nxt = h_r + PTR_W'(1);
              s_nxt = h_r + PTR_W'(1);
            end
            default: begin
              s_nxt = s_r;
            end
          endcase
          seq_nxt = SQ_READ;
        end
      end
      SQ_FLUSH: begin
        if (out_free) begin
          if (last_r || hb_vld_r) begin
            out_rvalid_nxt = 1'b1;
            out_byte_nxt   = hb_vld_r ? hb_byte_r : 8'd0;
            out_flag_nxt   = hb_vld_r;
            out_last_nxt   = last_r;
          end
          if (last_r) begin
            in_word_nxt = 1'b0;
            skip_nxt    = 1'b0;
          end
          hb_vld_nxt = 1'b0;
          seq_nxt    = SQ_IDLE;
        end
      end
      default: begin
        seq_nxt = SQ_IDLE;
      end
    endcase

    // hold back one result so the final one can be marked
    if (emit) begin
      if (hb_vld_r) begin
        out_rvalid_nxt = 1'b1;
        out_byte_nxt   = hb_byte_r;
        out_flag_nxt   = 1'b1;
        out_last_nxt   = 1'b0;
      end
      hb_vld_nxt  = 1'b1;
      hb_byte_nxt = emit_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r        <= SQ_IDLE;
      phase_r      <= PH_IDLE;
      in_word_r    <= 1'b0;
      skip_r       <= 1'b0;
      last_r       <= 1'b0;
      h_r          <= '0;
      s_r          <= '0;
      t_r          <= '0;
      hb_vld_r     <= 1'b0;
      out_rvalid_r <= 1'b0;
    end else begin
      seq_r        <= seq_nxt;
      phase_r      <= phase_nxt;
      in_word_r    <= in_word_nxt;
      skip_r       <= skip_nxt;
      last_r       <= last_nxt;
      h_r          <= h_nxt;
      s_r          <= s_nxt;
      t_r          <= t_nxt;
      hb_vld_r     <= hb_vld_nxt;
      out_rvalid_r <= out_rvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r       <= hi_nxt;
    hb_byte_r  <= hb_byte_nxt;
    out_byte_r <= out_byte_nxt;
    out_flag_r <= out_flag_nxt;
    out_last_r <= out_last_nxt;
  end

  `QEWD_ASSERT(a_pend_bound, (pend_cnt <= PEND_LIM), "held sequence exceeds its bound")
  `QEWD_ASSERT(a_fill_bound, ((t_r - h_r) <= FILL_LIM), "byte buffer overrun")
  `QEWD_ASSERT(a_idle_empty, (phase_r == PH_IDLE) |-> (h_r == s_r), "bytes held in idle phase")
  `QEWD_ASSERT(a_text_end, (seq_r == SQ_FLUSH && last_r && out_free) |=> (!in_word_r && !skip_r && phase_r == PH_IDLE), "text end left state behind")
  `QEWD_ASSERT_ALWAYS(a_reset_idle, (!rst_n) |=> (seq_r == SQ_IDLE && !hb_vld_r), "sequencer not idle after reset")

endmodule

[sim/q_encoded_word_decoder_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Q-encoded word decoder testbench
// Streams header texts into the decoder under random input gaps and output
// stalls. A scoreboard decodes every accepted byte itself and compares each
// result transfer with the oldest expected character.
// ----------------------------------------------------------------------------
module q_encoded_word_decoder_test import qewd_pkg::*; ();

  localparam int         CSET_MAX      = QEWD_MAX_CHARSET;
  localparam int         HELD_DEPTH    = CSET_MAX + 4;
  localparam int         MAX_PER_BYTE  = 40;
  localparam int         RANDOM_BYTES  = 360;
  localparam logic [7:0] CH_LOWER_Q    = 8'h71;

  typedef struct {
    bit [7:0] text;
    bit       valid;
    bit       last;
  } q_char_t;

  class q_decode_board;
    bit       word_mode;
    bit       drop_space;
    phase_t   phase;
    bit [7:0] held[HELD_DEPTH];
    int       held_n;
    bit [7:0] rescan[$];
    q_char_t  step_out[$];
    q_char_t  expected_chars[$];
    int       errors;

    function new();
      word_mode  = 0;
      drop_space = 0;
      phase      = PH_IDLE;
      held_n     = 0;
      errors     = 0;
    endfunction

    function int hex_nibble(bit [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
      if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
      return -1;
    endfunction

    function void push_char(bit [7:0] c);
      q_char_t r;
      r.text  = c;
      r.valid = 1;
      r.last  = 0;
      if (step_out.size() < MAX_PER_BYTE) step_out.push_back(r);
    endfunction

    function void hold_byte(bit [7:0] c);
      if (held_n < HELD_DEPTH) begin
        held[held_n] = c;
        held_n++;
      end
    endfunction

    // release the first held byte, requeue the rest ahead of unscanned bytes
    function void abandon();
      if (held_n > 0) push_char(held[0]);
      for (int i = held_n - 1; i >= 1; i--) rescan.push_front(held[i]);
      held_n = 0;
      phase  = PH_IDLE;
    endfunction

    function bit scan(bit [7:0] c);
      int hi;
      case (phase)
        PH_IDLE: begin
          if (drop_space) begin
            drop_space = 0;
            if (c == CH_SP) return 1;
          end
          if (c == CH_EQ) begin
            held_n = 0;
            hold_byte(c);
            phase = PH_EQ;
          end else if (c == CH_QM && word_mode) begin
            held_n = 0;
            hold_byte(c);
            phase = PH_END;
          end else if (c == CH_US && word_mode) begin
            push_char(CH_SP);
          end else begin
            push_char(c);
          end
          return 1;
        end
        PH_EQ: begin
          if (c == CH_QM) begin
            hold_byte(c);
            phase = PH_CSET;
            return 1;
          end
          if (hex_nibble(c) >= 0) begin
            hold_byte(c);
            phase = PH_HEX;
            return 1;
          end
        end
        PH_HEX: begin
          if (hex_nibble(c) >= 0 && held_n >= 2) begin
            hi = hex_nibble(held[1]);
            if (hi < 0) hi = 0;
            push_char(8'(hi * 16 + hex_nibble(c)));
            held_n = 0;
            phase  = PH_IDLE;
            return 1;
          end
        end
        PH_CSET: begin
          if (c == CH_QM) begin
            hold_byte(c);
            phase = PH_ENC;
            return 1;
          end
          if (held_n - 2 < CSET_MAX) begin
            hold_byte(c);
            return 1;
          end
        end
        PH_ENC: begin
          if (c == CH_Q) begin
            hold_byte(c);
            phase = PH_Q;
            return 1;
          end
        end
        PH_Q: begin
          if (c == CH_QM) begin
            word_mode = 1;
            held_n    = 0;
            phase     = PH_IDLE;
            return 1;
          end
        end
        PH_END: begin
          if (c == CH_EQ) begin
            word_mode  = 0;
            drop_space = 1;
            held_n     = 0;
            phase      = PH_IDLE;
            return 1;
          end
        end
        default: ;
      endcase
      abandon();
      return 0;
    endfunction

    function void drain();
      while (rescan.size() > 0) begin
        if (scan(rescan[0])) void'(rescan.pop_front());
      end
    endfunction

    function void note_byte(bit [7:0] b, bit last);
      q_char_t r;
      step_out.delete();
      rescan.delete();
      rescan.push_back(b);
      drain();
      if (last) begin
        while (phase != PH_IDLE) begin
          abandon();
          drain();
        end
        word_mode  = 0;
        drop_space = 0;
        held_n     = 0;
        if (step_out.size() == 0) begin
          r.text  = 8'h00;
          r.valid = 0;
          r.last  = 0;
          step_out.push_back(r);
        end
        step_out[step_out.size() - 1].last = 1;
      end
      foreach (step_out[i]) expected_chars.push_back(step_out[i]);
    endfunction

    function void check_char(bit [7:0] b, bit v, bit l);
      q_char_t e;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected transfer byte %02h valid %0d last %0d", $time, b, v, l);
        errors++;
        return;
      end
      e = expected_chars.pop_front();
      if (e.text !== b) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, e.text, b);
        errors++;
      end
      if (e.valid !== v) begin
        $display("%0t: out_valid expected %0d actual %0d", $time, e.valid, v);
        errors++;
      end
      if (e.last !== l) begin
        $display("%0t: out_last expected %0d actual %0d", $time, e.last, l);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_chars.size();
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte    = 8'h00;
  logic       in_is_last = 1'b0;
  logic       out_rvalid;
  logic       out_stall  = 1'b0;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  q_decode_board board      = new();
  bit [7:0]      text_q[$];
  int            sent       = 0;
  bit            calm       = 0;
  int            stall_left = 0;
  string         hex_digits = "0123456789ABCDEFabcdef";

  q_encoded_word_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_is_last(in_is_last),
    .out_rvalid(out_rvalid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_last  (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if ($urandom_range(0, 149) == 0) calm <= !calm;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!calm && $urandom_range(0, 2) == 0) begin
      stall_left <= idle_len();
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_rvalid && !out_stall) board.check_char(out_byte, out_valid, out_last);
  end

  task automatic send_byte(input bit [7:0] b, input bit last);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    in_is_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(b, last);
    sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic bit [7:0] byte_except(bit [7:0] a, bit [7:0] b);
    bit [7:0] r;
    do r = 8'($urandom_range(0, 255)); while (r == a || r == b);
    return r;
  endfunction

  function automatic int cset_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 8);
    return $urandom_range(CSET_MAX - 4, CSET_MAX + 4);
  endfunction

  function automatic void add_escape(bit broken);
    text_q.push_back(CH_EQ);
    text_q.push_back(hex_digits[$urandom_range(0, 21)]);
    text_q.push_back(broken ? 8'($urandom_range(0, 255)) : hex_digits[$urandom_range(0, 21)]);
  endfunction

  function automatic void add_opener(int len, bit lower_q);
    text_q.push_back(CH_EQ);
    text_q.push_back(CH_QM);
    repeat (len) text_q.push_back(byte_except(CH_QM, CH_QM));
    text_q.push_back(CH_QM);
    text_q.push_back(lower_q ? CH_LOWER_Q : CH_Q);
    text_q.push_back(CH_QM);
  endfunction

  function automatic void add_word();
    add_opener(cset_len(), 0);
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 4))
        0: text_q.push_back(CH_US);
        1: add_escape(0);
        2: begin
          text_q.push_back(CH_QM);
          text_q.push_back(byte_except(CH_EQ, CH_EQ));
        end
        default: text_q.push_back(byte_except(CH_EQ, CH_QM));
      endcase
    end
    if ($urandom_range(0, 5) != 0) begin
      text_q.push_back(CH_QM);
      text_q.push_back(CH_EQ);
    end
    if ($urandom_range(0, 1) != 0) text_q.push_back(CH_SP);
  endfunction

  function automatic void build_text();
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: text_q.push_back(8'($urandom_range(0, 255)));
        7, 8, 9:             add_escape(0);
        10:                  add_escape(1);
        11:                  add_opener(cset_len(), 1);
        12: begin
          add_opener(cset_len(), 0);
          repeat ($urandom_range(1, 3)) void'(text_q.pop_back());
        end
        default:             add_word();
      endcase
    end
    if (text_q.size() > 2 && $urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 2)) void'(text_q.pop_back());
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    add_str("=4a");
    send_text();
    add_str("=?a?q?=?a?Q?_?x?= ");
    send_text();
    add_str("=4");
    send_text();

    add_opener(CSET_MAX + 1, 0);
    add_str("abc");
    send_text();
    add_opener(CSET_MAX, 0);
    add_str("_=3d?=");
    send_text();

    while (sent < RANDOM_BYTES) begin
      build_text();
      send_text();
    end
    in_valid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/qewd_pkg.sv
sv/qewd_ram.sv
sv/qewd_scan.sv
sv/q_encoded_word_decoder.sv
sim/q_encoded_word_decoder_test.sv
